### sv/telnet_option_negotiator_unit_defines.svh
// Assertion macros for the telnet option negotiator.
// They expect clk and rst in the scope where they are used.
`ifndef TELNET_OPTION_NEGOTIATOR_UNIT_DEFINES_SVH
`define TELNET_OPTION_NEGOTIATOR_UNIT_DEFINES_SVH

// Same-cycle implication.
`define TON_ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("telnet negotiator check failed");

// Next-cycle implication.
`define TON_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("telnet negotiator check failed");

`endif

### sv/ton_pkg.sv
package ton_pkg;

  localparam logic [7:0] B_IAC  = 8'd255;
  localparam logic [7:0] B_DONT = 8'd254;
  localparam logic [7:0] B_DO   = 8'd253;
  localparam logic [7:0] B_WONT = 8'd252;
  localparam logic [7:0] B_WILL = 8'd251;
  localparam logic [7:0] B_SB   = 8'd250;
  localparam logic [7:0] B_SE   = 8'd240;

  localparam logic [7:0] OPT_ECHO  = 8'd1;
  localparam logic [7:0] OPT_SGA   = 8'd3;
  localparam logic [7:0] OPT_TTYPE = 8'd24;
  localparam logic [7:0] OPT_NAWS  = 8'd31;

  // Held verb codes (verb minus WILL).
  localparam logic [1:0] VERB_WILL = 2'd0;
  localparam logic [1:0] VERB_WONT = 2'd1;
  localparam logic [1:0] VERB_DO   = 2'd2;
  localparam logic [1:0] VERB_DONT = 2'd3;

  // Command queue sizing.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Byte index within one output run (longest run is 20 bytes).
  localparam int IDX_W = 5;

  typedef enum logic [2:0] {
    MODE_DATA   = 3'd0,
    MODE_IAC    = 3'd1,
    MODE_VERB   = 3'd2,
    MODE_SBOPT  = 3'd3,
    MODE_SBBODY = 3'd4,
    MODE_SBIAC  = 3'd5
  } mode_t;

  typedef enum logic [1:0] {
    CMD_DATA  = 2'd0,
    CMD_REPLY = 2'd1,
    CMD_TTYPE = 2'd2,
    CMD_NAWS  = 2'd3
  } cmd_kind_t;

  // One queued command; opt also carries the data byte of CMD_DATA.
  typedef struct packed {
    cmd_kind_t   kind;
    logic [7:0]  ans;
    logic [7:0]  opt;
    logic [15:0] cols;
    logic [15:0] rows;
  } cmd_t;

  function automatic logic [IDX_W-1:0] cmd_last_idx(input cmd_kind_t kind);
    logic [IDX_W-1:0] n;
    unique case (kind)
      CMD_DATA:  n = IDX_W'(0);
      CMD_REPLY: n = IDX_W'(2);
      CMD_TTYPE: n = IDX_W'(19);
      CMD_NAWS:  n = IDX_W'(8);
      default:   n = IDX_W'(0);
    endcase
    return n;
  endfunction

  // IAC SB TTYPE IS "xterm-256color" IAC SE
  function automatic logic [7:0] ttype_byte(input logic [IDX_W-1:0] idx);
    logic [7:0] b;
    unique case (idx)
      IDX_W'(0):  b = B_IAC;
      IDX_W'(1):  b = B_SB;
      IDX_W'(2):  b = OPT_TTYPE;
      IDX_W'(3):  b = 8'h00;
      IDX_W'(4):  b = 8'h78;
      IDX_W'(5):  b = 8'h74;
      IDX_W'(6):  b = 8'h65;
      IDX_W'(7):  b = 8'h72;
      IDX_W'(8):  b = 8'h6d;
      IDX_W'(9):  b = 8'h2d;
      IDX_W'(10): b = 8'h32;
      IDX_W'(11): b = 8'h35;
      IDX_W'(12): b = 8'h36;
      IDX_W'(13): b = 8'h63;
      IDX_W'(14): b = 8'h6f;
      IDX_W'(15): b = 8'h6c;
      IDX_W'(16): b = 8'h6f;
      IDX_W'(17): b = 8'h72;
      IDX_W'(18): b = B_IAC;
      IDX_W'(19): b = B_SE;
      default:    b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] naws_byte(input cmd_t c, input logic [IDX_W-1:0] idx);
    logic [7:0] b;
    unique case (idx)
      IDX_W'(0): b = B_IAC;
      IDX_W'(1): b = B_SB;
      IDX_W'(2): b = OPT_NAWS;
      IDX_W'(3): b = c.cols[15:8];
      IDX_W'(4): b = c.cols[7:0];
      IDX_W'(5): b = c.rows[15:8];
      IDX_W'(6): b = c.rows[7:0];
      IDX_W'(7): b = B_IAC;
      IDX_W'(8): b = B_SE;
      default:   b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] cmd_byte(input cmd_t c, input logic [IDX_W-1:0] idx);
    logic [7:0] b;
    unique case (c.kind)
      CMD_DATA:  b = c.opt;
      CMD_REPLY: begin
        if (idx == IDX_W'(0)) b = B_IAC;
        else if (idx == IDX_W'(1)) b = c.ans;
        else b = c.opt;
      end
      CMD_TTYPE: b = ttype_byte(idx);
      CMD_NAWS:  b = naws_byte(c, idx);
      default:   b = c.opt;
    endcase
    return b;
  endfunction

endpackage

### sv/ton_intf.sv
interface ton_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [7:0]  rx_byte;
  logic [15:0] cols;
  logic [15:0] rows;

  modport source(output valid, opcode, rx_byte, cols, rows, input ready);
  modport sink(input valid, opcode, rx_byte, cols, rows, output ready);
endinterface

interface ton_out_if;
  logic       valid;
  logic       ready;
  logic       to_host;
  logic [7:0] out_byte;
  logic       last;

  modport source(output valid, to_host, out_byte, last, input ready);
  modport sink(input valid, to_host, out_byte, last, output ready);
endinterface

### sv/ton_front.sv
module ton_front
  import ton_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  ton_in_if.sink     in_ch,
  input  logic       q_full,
  output logic       push,
  output cmd_t       push_cmd,
  output mode_t      mode
);

  mode_t      mode_next;
  logic [1:0] verb, verb_next;
  logic [7:0] sub_opt, sub_opt_next;
  logic       accept;
  logic       want;
  logic [7:0] b;
  logic [7:0] ans;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign b           = in_ch.rx_byte;

  // Next parse state.
  always_comb begin
    mode_next    = mode;
    verb_next    = verb;
    sub_opt_next = sub_opt;
    if (!in_ch.opcode) begin
      unique case (mode)
        MODE_IAC: begin
          if (b == B_IAC) begin
            mode_next = MODE_DATA;
          end else if (b >= B_WILL && b <= B_DONT) begin
            verb_next = 2'(b - B_WILL);
            mode_next = MODE_VERB;
          end else begin
            mode_next = (b == B_SB) ? MODE_SBOPT : MODE_DATA;
          end
        end
        MODE_VERB: mode_next = MODE_DATA;
        MODE_SBOPT: begin
          sub_opt_next = b;
          mode_next    = MODE_SBBODY;
        end
        MODE_SBBODY: begin
          if (b == B_IAC) mode_next = MODE_SBIAC;
        end
        MODE_SBIAC: begin
          if (b == B_SE) mode_next = MODE_DATA;
          else if (b != B_IAC) mode_next = MODE_SBBODY;
        end
        default: mode_next = (b == B_IAC) ? MODE_IAC : MODE_DATA;
      endcase
    end
  end

  // Reply policy.
  always_comb begin
    unique case (verb)
      VERB_DO:   ans = (b == OPT_NAWS || b == OPT_TTYPE) ? B_WILL : B_WONT;
      VERB_DONT: ans = B_WONT;
      VERB_WILL: ans = (b == OPT_ECHO || b == OPT_SGA) ? B_DO : B_DONT;
      default:   ans = B_DONT;
    endcase
  end

  // Command for the back end.
  always_comb begin
    want          = 1'b0;
    push_cmd.kind = CMD_DATA;
    push_cmd.ans  = ans;
    push_cmd.opt  = b;
    push_cmd.cols = in_ch.cols;
    push_cmd.rows = in_ch.rows;
    if (in_ch.opcode) begin
      want          = 1'b1;
      push_cmd.kind = CMD_NAWS;
    end else begin
      unique case (mode)
        MODE_IAC: want = (b == B_IAC);
        MODE_VERB: begin
          want          = 1'b1;
          push_cmd.kind = CMD_REPLY;
        end
        MODE_SBOPT, MODE_SBBODY: want = 1'b0;
        MODE_SBIAC: begin
          want          = (b == B_SE) && (sub_opt == OPT_TTYPE);
          push_cmd.kind = CMD_TTYPE;
        end
        default: want = (b != B_IAC);
      endcase
    end
  end

  assign push = accept && want;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= MODE_DATA;
      verb    <= VERB_WILL;
      sub_opt <= 8'd0;
    end else if (accept) begin
      mode    <= mode_next;
      verb    <= verb_next;
      sub_opt <= sub_opt_next;
    end
  end

endmodule

### sv/ton_queue.sv
module ton_queue
  import ton_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  cmd_t              push_cmd,
  input  logic              pop,
  output cmd_t              head,
  output logic              empty,
  output logic              full,
  output logic [QCNT_W-1:0] count
);

  cmd_t              slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;

  assign empty = (count == QCNT_W'(0));
  assign full  = (count == QCNT_W'(QDEPTH));
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (pop) rd_ptr <= rd_ptr + QPTR_W'(1);
      unique case ({push, pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

### sv/ton_back.sv
module ton_back
  import ton_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  cmd_t             head,
  input  logic             q_empty,
  output logic             pop,
  output logic [IDX_W-1:0] idx,
  ton_out_if.source        out_ch
);

  logic             ovalid;
  logic             ohost;
  logic [7:0]       obyte;
  logic             olast;
  logic             load;
  logic             emit;
  logic             is_last;

  assign load    = !ovalid || out_ch.ready;
  assign emit    = !q_empty && load;
  assign is_last = (idx == cmd_last_idx(head.kind));
  assign pop     = emit && is_last;

  assign out_ch.valid    = ovalid;
  assign out_ch.to_host  = ohost;
  assign out_ch.out_byte = obyte;
  assign out_ch.last     = olast;

  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
      idx    <= '0;
    end else if (emit) begin
      ovalid <= 1'b1;
      idx    <= is_last ? '0 : idx + IDX_W'(1);
    end else if (out_ch.ready) begin
      ovalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      ohost <= (head.kind != CMD_DATA);
      obyte <= cmd_byte(head, idx);
      olast <= is_last;
    end
  end

endmodule

### sv/telnet_option_negotiator_unit.sv
// Telnet option negotiator, receive side. Each input item is either one
// byte from the host (opcode 0) or a window resize request (opcode 1).
// Plain data bytes and an escaped IAC IAC leave on the output with to_host
// low; telnet commands are stripped. DO/DONT/WILL/WONT get a three-byte
// answer, a terminal-type subnegotiation gets the twenty-byte
// "xterm-256color" answer after its IAC SE, and a resize sends the nine-byte
// NAWS frame; all of these leave with to_host high, and last marks the final
// byte of each run. Parse state carries across items. The command queue
// holds four pending runs, and the output side drains one byte per cycle
// while the output accepts bytes. Input stalls only while the queue is full.
`include "telnet_option_negotiator_unit_defines.svh"

module telnet_option_negotiator_unit
  import ton_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  ton_in_if.sink    in_ch,
  ton_out_if.source out_ch
);

  logic              push;
  cmd_t              push_cmd;
  cmd_t              head;
  logic              pop;
  logic              q_empty;
  logic              q_full;
  logic [QCNT_W-1:0] q_count;
  logic [IDX_W-1:0]  idx;
  mode_t             mode;

  // Front end: parse received bytes, classify into runs to send.
  ton_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_ch    (in_ch),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd),
    .mode     (mode)
  );

  // Hold pending runs between the two sides.
  ton_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full),
    .count    (q_count)
  );

  // Back end: expand the head run into bytes, one per cycle while the output accepts them.
  ton_back u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (head),
    .q_empty (q_empty),
    .pop     (pop),
    .idx     (idx),
    .out_ch  (out_ch)
  );

  // Terminal-side bytes are always single-byte runs.
  `TON_ASSERT_NOW(a_data_is_last, out_ch.valid && !out_ch.to_host, out_ch.last)
  // A run in progress always has its command still queued.
  `TON_ASSERT_NOW(a_idx_has_cmd, idx != '0, !q_empty)
  // A resize never disturbs the parse state.
  `TON_ASSERT_NEXT(a_resize_keeps_mode, in_ch.valid && in_ch.ready && in_ch.opcode,
    mode == $past(mode))
  // Queue never overfills.
  `TON_ASSERT_NOW(a_queue_bound, push, q_count != QCNT_W'(QDEPTH) || pop)

endmodule
